[rtl/rtt_pkg.sv]
// Shared types and constants for the request timeout table.
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
  localparam int unsigned SEQ_W               = 32;
  localparam int unsigned TIME_W              = 32;
  localparam int unsigned TIMEOUT_W           = 16;
  localparam int unsigned CMD_W               = 3;
  localparam int unsigned STATUS_W            = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK          = 3'd0,
    CMD_ADD           = 3'd1,
    CMD_REMOVE        = 3'd2,
    CMD_QUERY_PRESENT = 3'd3,
    CMD_QUERY_TIMEOUT = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CHK,
    S_SCAN,
    S_ADVANCE,
    S_RESP
  } state_e;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

endpackage

[rtl/request_timeout_table.sv]
// Request timeout table: ring of outstanding sequence numbers with deadlines.
`timescale 1ns / 1ps
// Path from input transfer to result in the output register: add, unknown and
// empty-table commands go to S_RESP; tick via S_TICK_CHK, query via S_SCAN,
// remove via S_SCAN and, after a hit leaving entries, S_ADVANCE. One command is
// in work at a time; the scan reads the memory one slot per cycle via one read port.
// Reset clears the valid flags, pointers, count and time at once; entry memory
// contents stay undefined and are never read without a set valid flag.

module request_timeout_table #(
  parameter int unsigned TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEFAULT,
  localparam int unsigned SLOT_W     = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned OUT_BITS   = rtt_pkg::STATUS_W + 3 + CNT_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: timeout_ticks
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtt_pkg::TIMEOUT_W-1:0] cfg_data_i,
  // Command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rtt_pkg::SEQ_W-1:0]     s_axis_tdata,  // [31:0] seq_num
  input  logic [rtt_pkg::CMD_W-1:0]     s_axis_tuser,  // [2:0] command
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // from bit 0: status(2), present(1), timed_out(1), oldest_expired(1),
  // entry_count(CNT_W), zero padding
  output logic [OUT_DATA_W-1:0]         m_axis_tdata
);

  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(TABLE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_DEPTH - 1);

  rtt_pkg::state_e  state_q, state_d;
  rtt_pkg::cmd_e    cmd_q, cmd_d, in_cmd;
  logic [rtt_pkg::SEQ_W-1:0]     seq_q, seq_d;
  logic [rtt_pkg::TIME_W-1:0]    time_q, time_d;
  logic [rtt_pkg::TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [SLOT_W-1:0] append_q, append_d;
  logic [CNT_W-1:0]  count_q, count_d;

  // Scan bookkeeping
  logic [SLOT_W-1:0] scan_slot_q, scan_slot_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [CNT_W-1:0]  issued_q, issued_d;
  logic              pend_q, pend_d;

  // Pending result
  rtt_pkg::status_e  status_q, status_d;
  logic              present_q, present_d;
  logic              tmo_q, tmo_d;
  logic              oexp_q, oexp_d;

  // Output register
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // Store interface
  logic                   wr_en;
  rtt_pkg::entry_t        wr_entry;
  logic                   clr_en;
  logic [SLOT_W-1:0]      rd_slot;
  rtt_pkg::entry_t        rd_entry;
  logic [TABLE_DEPTH-1:0] valid;

  logic                      in_xfer;
  logic                      is_query;
  logic                      hit;
  logic                      scan_miss;
  logic                      resp_free;
  logic [rtt_pkg::TIME_W-1:0] age;
  logic                      reached;
  logic                      past;

  rtt_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_slot_i  (append_q),
    .wr_entry_i (wr_entry),
    .clr_en_i   (clr_en),
    .clr_slot_i (pend_slot_q),
    .rd_slot_i  (rd_slot),
    .rd_entry_o (rd_entry),
    .valid_o    (valid)
  );

  assign s_axis_tready = (state_q == rtt_pkg::S_IDLE);
  assign cfg_ready_o   = (state_q == rtt_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = rtt_pkg::cmd_e'(s_axis_tuser);

  assign is_query = (cmd_q == rtt_pkg::CMD_QUERY_PRESENT) ||
                    (cmd_q == rtt_pkg::CMD_QUERY_TIMEOUT);

  // Compare the entry read in the previous cycle; a miss is known once the
  // last slot of the ring has been compared.
  assign hit       = pend_q && valid[pend_slot_q] && (rd_entry.seq == seq_q);
  assign scan_miss = !hit && (issued_q == FULL_COUNT);

  // Wrapping time: reached when current time minus deadline is below half range.
  assign age     = time_q - rd_entry.deadline;
  assign reached = !age[rtt_pkg::TIME_W-1];
  assign past    = reached && (age != '0);

  assign resp_free = !m_valid_q || m_axis_tready;

  assign wr_entry.seq      = seq_d;
  assign wr_entry.deadline = time_q + rtt_pkg::TIME_W'(timeout_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtt_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == rtt_pkg::CMD_TICK && count_q != '0) begin
            state_d = rtt_pkg::S_TICK_CHK;
          end else if ((in_cmd == rtt_pkg::CMD_REMOVE ||
                        in_cmd == rtt_pkg::CMD_QUERY_PRESENT ||
                        in_cmd == rtt_pkg::CMD_QUERY_TIMEOUT) && count_q != '0) begin
            state_d = rtt_pkg::S_SCAN;
          end else begin
            state_d = rtt_pkg::S_RESP;
          end
        end
      end
      rtt_pkg::S_TICK_CHK: state_d = rtt_pkg::S_RESP;
      rtt_pkg::S_SCAN: begin
        if (hit) begin
          if (!is_query && count_q != CNT_W'(1)) begin
            state_d = rtt_pkg::S_ADVANCE;
          end else begin
            state_d = rtt_pkg::S_RESP;
          end
        end else if (scan_miss) begin
          state_d = rtt_pkg::S_RESP;
        end
      end
      rtt_pkg::S_ADVANCE: begin
        if (valid[oldest_q]) begin
          state_d = rtt_pkg::S_RESP;
        end
      end
      rtt_pkg::S_RESP: begin
        if (resp_free) begin
          state_d = rtt_pkg::S_IDLE;
        end
      end
      default: state_d = rtt_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    seq_d       = seq_q;
    time_d      = time_q;
    timeout_d   = timeout_q;
    oldest_d    = oldest_q;
    append_d    = append_q;
    count_d     = count_q;
    scan_slot_d = scan_slot_q;
    pend_slot_d = pend_slot_q;
    issued_d    = issued_q;
    pend_d      = pend_q;
    status_d    = status_q;
    present_d   = present_q;
    tmo_d       = tmo_q;
    oexp_d      = oexp_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    rd_slot     = oldest_q;

    if (cfg_valid_i && cfg_ready_o) begin
      timeout_d = cfg_data_i;
    end

    unique case (state_q)
      rtt_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_d       = in_cmd;
          seq_d       = s_axis_tdata;
          status_d    = rtt_pkg::ST_OK;
          present_d   = 1'b0;
          tmo_d       = 1'b0;
          oexp_d      = 1'b0;
          scan_slot_d = oldest_q;
          issued_d    = '0;
          pend_d      = 1'b0;
          unique case (in_cmd)
            rtt_pkg::CMD_TICK: begin
              // Advance time; the oldest entry is read now and checked next cycle.
              time_d = time_q + 1'b1;
              if (count_q == '0) begin
                status_d = rtt_pkg::ST_EMPTY;
              end
            end
            rtt_pkg::CMD_ADD: begin
              // Full when the count is at depth or the tail slot is still held.
              if (count_q == FULL_COUNT || valid[append_q]) begin
                status_d = rtt_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                append_d = (append_q == LAST_SLOT) ? '0 : append_q + 1'b1;
                count_d  = count_q + 1'b1;
                if (count_q == '0) begin
                  oldest_d = append_q;
                end
              end
            end
            rtt_pkg::CMD_REMOVE,
            rtt_pkg::CMD_QUERY_PRESENT,
            rtt_pkg::CMD_QUERY_TIMEOUT: begin
              if (count_q == '0) begin
                status_d = rtt_pkg::ST_EMPTY;
                tmo_d    = (in_cmd != rtt_pkg::CMD_REMOVE);
              end
            end
            default: ;
          endcase
        end
      end

      rtt_pkg::S_TICK_CHK: begin
        oexp_d = valid[oldest_q] && past;
      end

      rtt_pkg::S_SCAN: begin
        // Issue one read per cycle from the oldest slot around the ring.
        rd_slot = scan_slot_q;
        if (issued_q != FULL_COUNT) begin
          scan_slot_d = (scan_slot_q == LAST_SLOT) ? '0 : scan_slot_q + 1'b1;
          issued_d    = issued_q + 1'b1;
          pend_d      = 1'b1;
          pend_slot_d = scan_slot_q;
        end else begin
          pend_d = 1'b0;
        end
        if (hit) begin
          if (is_query) begin
            present_d = 1'b1;
            tmo_d     = reached;
          end else begin
            clr_en  = 1'b1;
            count_d = count_q - 1'b1;
            if (count_q == CNT_W'(1)) begin
              oldest_d = append_q;
            end
          end
        end else if (scan_miss) begin
          status_d = rtt_pkg::ST_NOT_FOUND;
          tmo_d    = is_query;
        end
      end

      rtt_pkg::S_ADVANCE: begin
        // Step the oldest pointer past slots that are no longer held.
        if (!valid[oldest_q]) begin
          oldest_d = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
        end
      end

      rtt_pkg::S_RESP: begin
        if (resp_free) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_DATA_W'({count_q, oexp_q, tmo_q, present_q, status_q});
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rtt_pkg::S_IDLE;
      time_q    <= '0;
      timeout_q <= rtt_pkg::TIMEOUT_RESET;
      oldest_q  <= '0;
      append_q  <= '0;
      count_q   <= '0;
      issued_q  <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      timeout_q <= timeout_d;
      oldest_q  <= oldest_d;
      append_q  <= append_d;
      count_q   <= count_d;
      issued_q  <= issued_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    seq_q       <= seq_d;
    scan_slot_q <= scan_slot_d;
    pend_slot_q <= pend_slot_d;
    status_q    <= status_d;
    present_q   <= present_d;
    tmo_q       <= tmo_d;
    oexp_q      <= oexp_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/rtt_store.sv]
// Entry memory with registered read and per-slot valid flags.
`timescale 1ns / 1ps

module rtt_store #(
  parameter int unsigned TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEFAULT,
  localparam int unsigned SLOT_W     = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [SLOT_W-1:0]      wr_slot_i,
  input  rtt_pkg::entry_t        wr_entry_i,
  input  logic                   clr_en_i,
  input  logic [SLOT_W-1:0]      clr_slot_i,
  input  logic [SLOT_W-1:0]      rd_slot_i,
  output rtt_pkg::entry_t        rd_entry_o,
  output logic [TABLE_DEPTH-1:0] valid_o
);

  rtt_pkg::entry_t        mem [TABLE_DEPTH];
  rtt_pkg::entry_t        rd_entry_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TABLE_DEPTH-1:0] valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i] <= wr_entry_i;
    end
    rd_entry_q <= mem[rd_slot_i];
  end

  always_comb begin
    valid_d = valid_q;
    if (clr_en_i) begin
      valid_d[clr_slot_i] = 1'b0;
    end
    if (wr_en_i) begin
      valid_d[wr_slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign valid_o    = valid_q;

endmodule

[tb/sv/rtt_checker.sv]
// Result checker for the request timeout table: mirrors the table and compares every result.
`timescale 1ns / 1ps

module rtt_checker #(
  parameter int unsigned DEPTH = rtt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rtt_pkg::TIMEOUT_W-1:0] cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [rtt_pkg::SEQ_W-1:0]     s_tdata_i,  // [31:0] seq_num
  input  logic [rtt_pkg::CMD_W-1:0]     s_tuser_i,  // [2:0] command
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // status(2), present(1), timed_out(1), oldest_expired(1), entry_count(CNT_W), zero padding
  input  logic [OUT_W-1:0]              m_tdata_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);

  typedef struct {
    rtt_pkg::status_e status;
    logic             present;
    logic             timed_out;
    logic             oldest_expired;
    logic [CNT_W-1:0] count;
  } outcome_t;

  // Mirror of the table contents and bookkeeping
  logic [rtt_pkg::SEQ_W-1:0]     slot_seq      [DEPTH];
  logic [rtt_pkg::TIME_W-1:0]    slot_deadline [DEPTH];
  logic                          slot_held     [DEPTH];
  int unsigned                   oldest_slot;
  int unsigned                   tail_slot;
  int unsigned                   held_count;
  logic [rtt_pkg::TIME_W-1:0]    now_ticks;
  logic [rtt_pkg::TIMEOUT_W-1:0] timeout_ticks;

  outcome_t    awaited_q[$];
  int unsigned fails = 0;

  assign fail_count_o = fails;

  function automatic int unsigned wrap_next(int unsigned p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  // Oldest held slot carrying this number, DEPTH when absent.
  function automatic int unsigned oldest_match(logic [rtt_pkg::SEQ_W-1:0] seq);
    int unsigned p;
    p = oldest_slot;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_held[p] && slot_seq[p] == seq) return p;
      p = wrap_next(p);
    end
    return DEPTH;
  endfunction

  function automatic outcome_t apply_command(rtt_pkg::cmd_e cmd,
                                             logic [rtt_pkg::SEQ_W-1:0] seq);
    outcome_t                   r;
    int unsigned                hit;
    logic [rtt_pkg::TIME_W-1:0] lag;
    r.status         = rtt_pkg::ST_OK;
    r.present        = 1'b0;
    r.timed_out      = 1'b0;
    r.oldest_expired = 1'b0;
    case (cmd)
      rtt_pkg::CMD_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (held_count == 0) begin
          r.status = rtt_pkg::ST_EMPTY;
        end else if (slot_held[oldest_slot]) begin
          // past: wrapped difference non-zero and below half range
          lag = now_ticks - slot_deadline[oldest_slot];
          r.oldest_expired = (lag != '0) && !lag[rtt_pkg::TIME_W-1];
        end
      end
      rtt_pkg::CMD_ADD: begin
        if (held_count >= DEPTH || slot_held[tail_slot]) begin
          r.status = rtt_pkg::ST_FULL;
        end else begin
          slot_seq[tail_slot]      = seq;
          slot_deadline[tail_slot] = now_ticks + rtt_pkg::TIME_W'(timeout_ticks);
          slot_held[tail_slot]     = 1'b1;
          if (held_count == 0) oldest_slot = tail_slot;
          tail_slot = wrap_next(tail_slot);
          held_count++;
        end
      end
      rtt_pkg::CMD_REMOVE, rtt_pkg::CMD_QUERY_PRESENT, rtt_pkg::CMD_QUERY_TIMEOUT: begin
        hit = (held_count == 0) ? DEPTH : oldest_match(seq);
        if (hit == DEPTH) begin
          r.status    = (held_count == 0) ? rtt_pkg::ST_EMPTY : rtt_pkg::ST_NOT_FOUND;
          r.timed_out = (cmd != rtt_pkg::CMD_REMOVE);
        end else if (cmd == rtt_pkg::CMD_REMOVE) begin
          slot_held[hit] = 1'b0;
          held_count--;
          if (held_count == 0) begin
            oldest_slot = tail_slot;
          end else begin
            for (int i = 0; i < DEPTH && !slot_held[oldest_slot]; i++)
              oldest_slot = wrap_next(oldest_slot);
          end
        end else begin
          r.present = 1'b1;
          lag = now_ticks - slot_deadline[hit];
          r.timed_out = !lag[rtt_pkg::TIME_W-1];
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held_count);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) slot_held[i] = 1'b0;
      oldest_slot   = 0;
      tail_slot     = 0;
      held_count    = 0;
      now_ticks     = '0;
      timeout_ticks = rtt_pkg::TIMEOUT_RESET;
      awaited_q.delete();
      pending_o <= 0;
    end else begin
      // Compare first: a result leaving now belongs to an earlier command
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata_i);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, m_tdata_i[1:0]);
          check_field("present", want.present, m_tdata_i[2]);
          check_field("timed_out", want.timed_out, m_tdata_i[3]);
          check_field("oldest_expired", want.oldest_expired, m_tdata_i[4]);
          check_field("entry_count", want.count, m_tdata_i[5 +: CNT_W]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) timeout_ticks = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        awaited_q.push_back(apply_command(rtt_pkg::cmd_e'(s_tuser_i), s_tdata_i));
      pending_o <= awaited_q.size();
    end
  end

endmodule

[tb/sv/tb_request_timeout_table.sv]
// Testbench top for the request timeout table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_request_timeout_table;

  localparam int unsigned OUT_W        = 16;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 150;
  // Receiver hold-off long enough to back the block up well past one command
  localparam int unsigned STALL_CYCLES = 300;
  // Longest command (remove with full scans) plus margin
  localparam int unsigned DRAIN_CYCLES = 2 * rtt_pkg::TABLE_DEPTH_DEFAULT + 10;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rtt_pkg::TIMEOUT_W-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [rtt_pkg::SEQ_W-1:0]     in_seq;
  logic [rtt_pkg::CMD_W-1:0]     in_cmd;
  logic                          out_valid;
  logic                          out_ready;
  logic [OUT_W-1:0]              out_data;

  int unsigned pending;
  int unsigned fail_count;

  // Shared pacing state between the sender and the receiver
  int unsigned sent_count = 0;
  logic        steady     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_timeout_table u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_seq),
    .s_axis_tuser  (in_cmd),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data)
  );

  rtt_checker #(.OUT_W(OUT_W)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (in_valid),
    .s_tready_i   (in_ready),
    .s_tdata_i    (in_seq),
    .s_tuser_i    (in_cmd),
    .m_tvalid_i   (out_valid),
    .m_tready_i   (out_ready),
    .m_tdata_i    (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Offer one command; idle now and then unless in the steady stretch, then hold
  // the command until its transfer.
  task automatic send_item(rtt_pkg::cmd_e cmd, logic [rtt_pkg::SEQ_W-1:0] seq);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_seq   <= seq;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    steady <= (sent_count >= 700 && sent_count < 950);
  endtask

  // Write the timeout register once the block has drained. Every command gives
  // exactly one result, so an empty expectation store means the block is idle.
  task automatic write_timeout(logic [rtt_pkg::TIMEOUT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus one long hold-off while the sender keeps
  // offering, so the block fills and stalls its input.
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && sent_count >= 400) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      out_ready <= steady || ($urandom_range(99) >= 16);
    end
  end

  // Sender and verdict
  initial begin
    logic [rtt_pkg::TIMEOUT_W-1:0] phase_timeout [PHASES];
    logic [rtt_pkg::SEQ_W-1:0]     seq_pool [6];
    int unsigned                   roll;
    bit                            fill;
    rtt_pkg::cmd_e                 cmd;
    logic [rtt_pkg::SEQ_W-1:0]     seq;

    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_seq    <= '0;
    in_cmd    <= rtt_pkg::CMD_TICK;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset timeout of five ticks.
    // Empty table: tick, remove and both queries
    send_item(rtt_pkg::CMD_TICK, 32'd0);
    send_item(rtt_pkg::CMD_REMOVE, 32'd7);
    send_item(rtt_pkg::CMD_QUERY_PRESENT, 32'd7);
    send_item(rtt_pkg::CMD_QUERY_TIMEOUT, 32'd7);
    // Field extremes and a duplicate
    send_item(rtt_pkg::CMD_ADD, 32'd0);
    send_item(rtt_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_item(rtt_pkg::CMD_ADD, 32'd0);
    send_item(rtt_pkg::CMD_QUERY_PRESENT, 32'd0);
    send_item(rtt_pkg::CMD_QUERY_TIMEOUT, 32'hFFFF_FFFF);
    // Missing numbers
    send_item(rtt_pkg::CMD_QUERY_PRESENT, 32'h1234_5678);
    send_item(rtt_pkg::CMD_QUERY_TIMEOUT, 32'h1234_5678);
    send_item(rtt_pkg::CMD_REMOVE, 32'd9);
    // Advance past the deadlines so the oldest entry expires
    repeat (6) send_item(rtt_pkg::CMD_TICK, $urandom);
    send_item(rtt_pkg::CMD_QUERY_TIMEOUT, 32'd0);
    // Leave a hole in the middle, then drop the oldest copy, then empty the table
    send_item(rtt_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
    send_item(rtt_pkg::CMD_REMOVE, 32'd0);
    send_item(rtt_pkg::CMD_REMOVE, 32'd0);
    send_item(rtt_pkg::CMD_TICK, 32'd0);

    // Random part: one timeout per phase, zero and both ends of the range among them
    phase_timeout = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd1, 16'd2, 16'd6, 16'd4};
    phase_timeout[4] = 16'($urandom_range(65535, 1));

    for (int ph = 0; ph < PHASES; ph++) begin
      write_timeout(phase_timeout[ph]);
      // Small pool of numbers per phase so adds, removes and queries hit each other
      seq_pool[0] = ph[0] ? 32'hFFFF_FFFF : 32'd0;
      for (int k = 1; k < 6; k++) seq_pool[k] = $urandom;
      // Alternate phases that fill the table with phases that drain it
      fill = !ph[0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 20)                    cmd = rtt_pkg::CMD_TICK;
        else if (roll < (fill ? 60 : 35)) cmd = rtt_pkg::CMD_ADD;
        else if (roll < 75)               cmd = rtt_pkg::CMD_REMOVE;
        else if (roll < 87)               cmd = rtt_pkg::CMD_QUERY_PRESENT;
        else                              cmd = rtt_pkg::CMD_QUERY_TIMEOUT;
        seq = ($urandom_range(99) < 70) ? seq_pool[$urandom_range(5)] : $urandom;
        send_item(cmd, seq);
      end
    end

    // Drop valid, wait for every result, then allow a margin for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("request_timeout_table verification clean");
    end else begin
      $display("request_timeout_table verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1000000;
    $display("request_timeout_table verification failed");
    $finish;
  end

endmodule
